// ----- hw/rtl/fii_pkg.sv -----
// Shared types, widths, codes and reset values for the fractal iterator block.
package fii_pkg;

    // Number format and datapath widths
    localparam int COORD_W   = 48;               // z, c, d components, signed Q.F
    localparam int HALF_W    = COORD_W / 2;      // multiplier operand width
    localparam int PP_W      = 2 * HALF_W;       // one partial product
    localparam int ACC_W     = 2 * COORD_W + 4;  // exact sum of two products, with headroom

    // Field and register widths
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int ITER_W     = 16;
    localparam int OUTCOME_W  = 2;
    localparam int STEP_W     = 32;
    localparam int ESC_W      = 18;
    localparam int EPS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Parameter defaults
    localparam int DEF_MAX_COLUMNS   = 1024;
    localparam int DEF_MAX_ROWS      = 512;
    localparam int DEF_FRACTION_BITS = 28;

    // Saturation bounds of one component
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Register reset values
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_REAL = -48'sd419430400;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_IMAG = -48'sd9385855;
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP  = 32'd39108;
    localparam logic [ESC_W-1:0]          RST_ESCAPE      = 18'd100000;
    localparam logic [ITER_W-1:0]         RST_ITER_LIMIT  = 16'd1000;
    localparam logic [EPS_W-1:0]          RST_EPSILON_SQ  = 32'd268;
    localparam logic                      RST_INTERIOR_ON = 1'b1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_REAL     = 3'd0,
        REG_ORIGIN_IMAG     = 3'd1,
        REG_PIXEL_STEP      = 3'd2,
        REG_ESCAPE_LIMIT    = 3'd3,
        REG_ITERATION_LIMIT = 3'd4,
        REG_EPSILON_SQUARED = 3'd5,
        REG_INTERIOR_TEST   = 3'd6
    } cfg_idx_t;

    // Outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ESCAPED  = 2'd0,
        OUT_INTERIOR = 2'd1,
        OUT_LIMIT    = 2'd2
    } outcome_t;

    // Input word
    typedef struct packed {
        logic [COL_W-1:0] pixel_column;
        logic [ROW_W-1:0] pixel_row;
    } pixel_t;

    // Result word
    typedef struct packed {
        logic [ITER_W-1:0]    iteration_count;
        logic [OUTCOME_W-1:0] outcome;
    } result_t;

    // Configuration register file
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_real;
        logic signed [COORD_W-1:0] origin_imag;
        logic [STEP_W-1:0]         pixel_step;
        logic [ESC_W-1:0]          escape_limit;
        logic [ITER_W-1:0]         iteration_limit;
        logic [EPS_W-1:0]          epsilon_squared;
        logic                      interior_test_on;
    } cfg_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic       issue;   // form one partial product this cycle
        logic       clear;   // zero the accumulator
        logic       negate;  // subtract this product's term
        logic [1:0] part;    // [0] picks the half of a, [1] the half of b
    } mac_ctrl_t;

    // Handshake between top level and sequencer
    typedef struct packed {
        logic start;
        logic take;
    } seq_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

// ----- hw/rtl/fii_mac.sv -----
// Shared multiplier and accumulator: one 24x24 partial product per cycle, summed exactly.
module fii_mac
    import fii_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [COORD_W-1:0] op_a,
    input  logic signed [COORD_W-1:0] op_b,
    output logic signed [ACC_W-1:0]   acc
);

    logic [COORD_W-1:0]       a_mag;
    logic [COORD_W-1:0]       b_mag;
    logic [HALF_W-1:0]        a_half;
    logic [HALF_W-1:0]        b_half;
    logic [PP_W-1:0]          pp_next;
    logic [PP_W-1:0]          pp_reg;
    logic [1:0]               sh_next;
    logic [1:0]               sh_reg;
    logic                     sub_next;
    logic                     sub_reg;
    logic                     vld_reg;
    logic [ACC_W-1:0]         term;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;

    // Sign-magnitude split, pick halves, multiply
    always_comb begin
        a_mag    = op_a[COORD_W-1] ? COORD_W'(-op_a) : COORD_W'(op_a);
        b_mag    = op_b[COORD_W-1] ? COORD_W'(-op_b) : COORD_W'(op_b);
        a_half   = ctrl.part[0] ? a_mag[COORD_W-1:HALF_W] : a_mag[HALF_W-1:0];
        b_half   = ctrl.part[1] ? b_mag[COORD_W-1:HALF_W] : b_mag[HALF_W-1:0];
        pp_next  = PP_W'(a_half) * PP_W'(b_half);
        sh_next  = {1'b0, ctrl.part[0]} + {1'b0, ctrl.part[1]};
        sub_next = ctrl.negate ^ op_a[COORD_W-1] ^ op_b[COORD_W-1];
    end

    always_ff @(posedge aclk) begin
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        sub_reg <= sub_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= ctrl.issue;
        end
    end

    // Align the registered partial product
    always_comb begin
        case (sh_reg)
            2'd0:    term = ACC_W'(pp_reg);
            2'd1:    term = ACC_W'(pp_reg) << HALF_W;
            2'd2:    term = ACC_W'(pp_reg) << (2 * HALF_W);
            default: term = '0;
        endcase
    end

    // Accumulate
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (vld_reg) begin
            acc_next = sub_reg ? (acc_reg - $signed(term)) : (acc_reg + $signed(term));
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/fii_seq.sv -----
// Pixel sequencer: sets up c, runs the escape and derivative iteration as jobs on the MAC.
module fii_seq
    import fii_pkg::*;
#(
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  seq_cmd_t                  cmd,
    input  pixel_t                    pixel,
    output seq_stat_t                 stat,
    output result_t                   result,
    output mac_ctrl_t                 mac_ctrl,
    output logic signed [COORD_W-1:0] op_a,
    output logic signed [COORD_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]   acc
);

    localparam int SEQ_STEP_W  = 4;
    localparam int ISSUE_STEPS = 8;   // two products, four partial products each
    localparam int LAST_STEP   = 9;   // accumulator settled, result used
    localparam int FIN_W       = ACC_W + 2;

    localparam logic signed [COORD_W-1:0] D_ONE   = COORD_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [FIN_W-1:0]   SAT_HI  = FIN_W'(COORD_MAX);
    localparam logic signed [FIN_W-1:0]   SAT_LO  = FIN_W'(COORD_MIN);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } seq_state_t;

    typedef enum logic [2:0] {
        JOB_CRE  = 3'd0,   // c_re = origin_real + step * column
        JOB_CIM  = 3'd1,   // c_im = origin_imag + step * row
        JOB_DMAG = 3'd2,   // |d|^2
        JOB_ZMAG = 3'd3,   // |z|^2
        JOB_DRE  = 3'd4,   // 2 (d_re z_re - d_im z_im)
        JOB_DIM  = 3'd5,   // 2 (d_re z_im + d_im z_re)
        JOB_ZRE  = 3'd6,   // z_re^2 - z_im^2 + c_re
        JOB_ZIM  = 3'd7    // 2 z_re z_im + c_im
    } job_t;

    seq_state_t                state_reg, state_next;
    job_t                      job_reg, job_next;
    logic [SEQ_STEP_W-1:0]     step_reg, step_next;
    logic [ITER_W-1:0]         iter_reg, iter_next, iter_inc;
    logic [ITER_W-1:0]         limit_reg, limit_next;
    logic                      intr_reg, intr_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic signed [COORD_W-1:0] c_re_reg, c_re_next, c_im_reg, c_im_next;
    logic signed [COORD_W-1:0] z_re_reg, z_re_next, z_im_reg, z_im_next;
    logic signed [COORD_W-1:0] d_re_reg, d_re_next, d_im_reg, d_im_next;
    logic signed [COORD_W-1:0] nd_re_reg, nd_re_next, nd_im_reg, nd_im_next;
    logic signed [COORD_W-1:0] nz_re_reg, nz_re_next;
    result_t                   res_reg, res_next;

    logic                      prod_sel;
    logic                      neg;
    logic                      dbl;
    logic                      scale;
    logic signed [COORD_W-1:0] fin_add;
    logic signed [FIN_W-1:0]   fin_pre, fin_shift, fin_sum;
    logic signed [COORD_W-1:0] fin_val;
    logic [ACC_W-1:0]          esc_cmp, eps_cmp;
    logic                      d_small, z_out;
    job_t                      loop_job;

    // Operand and finish selection per job
    assign prod_sel = step_reg[2];

    always_comb begin
        op_a    = '0;
        op_b    = '0;
        neg     = 1'b0;
        dbl     = 1'b0;
        scale   = 1'b1;
        fin_add = '0;
        case (job_reg)
            JOB_CRE: begin
                op_a    = prod_sel ? '0 : COORD_W'(cfg.pixel_step);
                op_b    = prod_sel ? '0 : COORD_W'(col_reg);
                scale   = 1'b0;
                fin_add = cfg.origin_real;
            end
            JOB_CIM: begin
                op_a    = prod_sel ? '0 : COORD_W'(cfg.pixel_step);
                op_b    = prod_sel ? '0 : COORD_W'(row_reg);
                scale   = 1'b0;
                fin_add = cfg.origin_imag;
            end
            JOB_DMAG: begin
                op_a = prod_sel ? d_im_reg : d_re_reg;
                op_b = prod_sel ? d_im_reg : d_re_reg;
            end
            JOB_ZMAG: begin
                op_a = prod_sel ? z_im_reg : z_re_reg;
                op_b = prod_sel ? z_im_reg : z_re_reg;
            end
            JOB_DRE: begin
                op_a = prod_sel ? d_im_reg : d_re_reg;
                op_b = prod_sel ? z_im_reg : z_re_reg;
                neg  = prod_sel;
                dbl  = 1'b1;
            end
            JOB_DIM: begin
                op_a = prod_sel ? d_im_reg : d_re_reg;
                op_b = prod_sel ? z_re_reg : z_im_reg;
                dbl  = 1'b1;
            end
            JOB_ZRE: begin
                op_a    = prod_sel ? z_im_reg : z_re_reg;
                op_b    = prod_sel ? z_im_reg : z_re_reg;
                neg     = prod_sel;
                fin_add = c_re_reg;
            end
            JOB_ZIM: begin
                op_a    = z_re_reg;
                op_b    = z_im_reg;
                fin_add = c_im_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // MAC control
    always_comb begin
        mac_ctrl.issue  = (state_reg == ST_RUN) && (step_reg < SEQ_STEP_W'(ISSUE_STEPS));
        mac_ctrl.clear  = (state_reg == ST_RUN) && (step_reg == '0);
        mac_ctrl.negate = neg;
        mac_ctrl.part   = step_reg[1:0];
    end

    // Rescale, add offset, saturate to one component
    always_comb begin
        fin_pre   = dbl ? (FIN_W'(acc) <<< 1) : FIN_W'(acc);
        fin_shift = scale ? (fin_pre >>> FRACTION_BITS) : fin_pre;
        fin_sum   = fin_shift + FIN_W'(fin_add);
        if (fin_sum > SAT_HI) begin
            fin_val = COORD_MAX;
        end else if (fin_sum < SAT_LO) begin
            fin_val = COORD_MIN;
        end else begin
            fin_val = fin_sum[COORD_W-1:0];
        end
    end

    // Magnitude tests on the exact sum of squares
    always_comb begin
        esc_cmp  = ACC_W'(cfg.escape_limit) << (2 * FRACTION_BITS);
        eps_cmp  = ACC_W'(cfg.epsilon_squared) << FRACTION_BITS;
        d_small  = $unsigned(acc) < eps_cmp;
        z_out    = intr_reg ? (esc_cmp < $unsigned(acc)) : !($unsigned(acc) < esc_cmp);
        loop_job = intr_reg ? JOB_DMAG : JOB_ZMAG;
        iter_inc = iter_reg + 1'b1;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        iter_next  = iter_reg;
        limit_next = limit_reg;
        intr_next  = intr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        z_re_next  = z_re_reg;
        z_im_next  = z_im_reg;
        d_re_next  = d_re_reg;
        d_im_next  = d_im_reg;
        nd_re_next = nd_re_reg;
        nd_im_next = nd_im_reg;
        nz_re_next = nz_re_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    col_next   = (32'(pixel.pixel_column) >= 32'(MAX_COLUMNS)) ?
                                 COL_W'(MAX_COLUMNS - 1) : pixel.pixel_column;
                    row_next   = (32'(pixel.pixel_row) >= 32'(MAX_ROWS)) ?
                                 ROW_W'(MAX_ROWS - 1) : pixel.pixel_row;
                    limit_next = cfg.iteration_limit;
                    intr_next  = cfg.interior_test_on;
                    iter_next  = '0;
                    d_re_next  = D_ONE;
                    d_im_next  = '0;
                    job_next   = JOB_CRE;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg != SEQ_STEP_W'(LAST_STEP)) begin
                    step_next = step_reg + 1'b1;
                end else begin
                    step_next = '0;
                    case (job_reg)
                        JOB_CRE: begin
                            c_re_next = fin_val;
                            z_re_next = fin_val;
                            job_next  = JOB_CIM;
                        end
                        JOB_CIM: begin
                            c_im_next = fin_val;
                            z_im_next = fin_val;
                            // zero limit: no iteration at all
                            if (limit_reg == '0) begin
                                res_next.iteration_count = '0;
                                res_next.outcome         = OUT_LIMIT;
                                state_next               = ST_DONE;
                            end else begin
                                job_next = loop_job;
                            end
                        end
                        JOB_DMAG: begin
                            if (d_small) begin
                                res_next.iteration_count = iter_reg;
                                res_next.outcome         = OUT_INTERIOR;
                                state_next               = ST_DONE;
                            end else begin
                                job_next = JOB_ZMAG;
                            end
                        end
                        JOB_ZMAG: begin
                            if (z_out) begin
                                res_next.iteration_count = iter_reg;
                                res_next.outcome         = OUT_ESCAPED;
                                state_next               = ST_DONE;
                            end else begin
                                job_next = intr_reg ? JOB_DRE : JOB_ZRE;
                            end
                        end
                        JOB_DRE: begin
                            nd_re_next = fin_val;
                            job_next   = JOB_DIM;
                        end
                        JOB_DIM: begin
                            nd_im_next = fin_val;
                            job_next   = JOB_ZRE;
                        end
                        JOB_ZRE: begin
                            nz_re_next = fin_val;
                            job_next   = JOB_ZIM;
                        end
                        JOB_ZIM: begin
                            // commit the whole iteration at once
                            z_re_next = nz_re_reg;
                            z_im_next = fin_val;
                            if (intr_reg) begin
                                d_re_next = nd_re_reg;
                                d_im_next = nd_im_reg;
                            end
                            iter_next = iter_inc;
                            if (iter_inc == limit_reg) begin
                                res_next.iteration_count = limit_reg;
                                res_next.outcome         = OUT_LIMIT;
                                state_next               = ST_DONE;
                            end else begin
                                job_next = loop_job;
                            end
                        end
                        default: begin
                            job_next = JOB_CRE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (cmd.take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_CRE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg  <= iter_next;
        limit_reg <= limit_next;
        intr_reg  <= intr_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        c_re_reg  <= c_re_next;
        c_im_reg  <= c_im_next;
        z_re_reg  <= z_re_next;
        z_im_reg  <= z_im_next;
        d_re_reg  <= d_re_next;
        d_im_reg  <= d_im_next;
        nd_re_reg <= nd_re_next;
        nd_im_reg <= nd_im_next;
        nz_re_reg <= nz_re_next;
        res_reg   <= res_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign result    = res_reg;

    // Step counter stays inside one job
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> step_reg <= SEQ_STEP_W'(LAST_STEP))
        else $error("job step counter ran past its last step");

    // A running pixel never reaches its limit without having stopped
    a_iter_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && limit_reg != '0) |-> iter_reg < limit_reg)
        else $error("iteration count reached the limit while still running");

    // Limit outcome always reports the full count
    a_limit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_reg.outcome == OUT_LIMIT)
            |-> res_reg.iteration_count == limit_reg)
        else $error("limit outcome with a count other than the limit");

    // New pixels only start from idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> state_reg == ST_IDLE)
        else $error("pixel started while the sequencer was busy");

endmodule

// ----- hw/rtl/fractal_iterator_interior_detect_top.sv -----
// Top level: config registers, input and result handshakes, sequencer and shared MAC.
//
//  channel  | ports                          | word      | direction
//  ---------+--------------------------------+-----------+----------
//  input    | s_valid s_ready s_data         | pixel_t   | in
//  result   | m_valid m_ready m_data         | result_t  | out
//  config   | cfg_valid cfg_ready cfg_index  | 48b data  | in
//           | cfg_data                       |           |
//
//  Each pixel runs the c_re and c_im jobs, then per iteration the |d|^2, |z|^2, d and z jobs
//  in interior mode or the |z|^2 and z jobs in plain mode, plus the stop test jobs.
//  Every job runs on the single 24x24 multiplier: two 48x48 products of four
//  partial products each, then a step to settle and a step to use the sum.
//  Reset loads the register defaults; there is no clearing pass.
//  A result waits in the output register while the next pixel runs; a low m_ready
//  then stalls the sequencer in its done state, and s_ready stays low until it drains.
module fractal_iterator_interior_detect_top
    import fii_pkg::*;
#(
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                      cfg_reg, cfg_next;
    seq_cmd_t                  cmd;
    seq_stat_t                 stat;
    result_t                   result;
    mac_ctrl_t                 mac_ctrl;
    logic signed [COORD_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0]   acc;
    logic                      m_valid_reg, m_valid_next;
    result_t                   m_data_reg, m_data_next;

    // Register writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_REAL:     cfg_next.origin_real      = cfg_data;
                REG_ORIGIN_IMAG:     cfg_next.origin_imag      = cfg_data;
                REG_PIXEL_STEP:      cfg_next.pixel_step       = cfg_data[STEP_W-1:0];
                REG_ESCAPE_LIMIT:    cfg_next.escape_limit     = cfg_data[ESC_W-1:0];
                REG_ITERATION_LIMIT: cfg_next.iteration_limit  = cfg_data[ITER_W-1:0];
                REG_EPSILON_SQUARED: cfg_next.epsilon_squared  = cfg_data[EPS_W-1:0];
                REG_INTERIOR_TEST:   cfg_next.interior_test_on = cfg_data[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_real      <= RST_ORIGIN_REAL;
            cfg_reg.origin_imag      <= RST_ORIGIN_IMAG;
            cfg_reg.pixel_step       <= RST_PIXEL_STEP;
            cfg_reg.escape_limit     <= RST_ESCAPE;
            cfg_reg.iteration_limit  <= RST_ITER_LIMIT;
            cfg_reg.epsilon_squared  <= RST_EPSILON_SQ;
            cfg_reg.interior_test_on <= RST_INTERIOR_ON;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side
    assign s_ready   = stat.idle;
    assign cmd.start = s_valid && stat.idle;

    // Output register, loaded from the sequencer when empty or draining
    assign cmd.take = stat.done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.take) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    fii_seq #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .pixel    (s_data),
        .stat     (stat),
        .result   (result),
        .mac_ctrl (mac_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc      (acc)
    );

    fii_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc     (acc)
    );

endmodule
